[sv/bfic_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfic_pkg
// Shared sizes, codes and item types of the tape-language interpreter core.
// ----------------------------------------------------------------------------
package bfic_pkg;

    // storage sizes
    localparam int TAPE_CELLS  = 32768;
    localparam int CELL_BITS   = 8;
    localparam int PROG_DEPTH  = 4096;
    localparam int STACK_DEPTH = 64;

    // derived widths
    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int IP_W    = $clog2(PROG_DEPTH + 1);
    localparam int TAPE_AW = $clog2(TAPE_CELLS);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);

    typedef logic [CELL_BITS-1:0] t_cell;

    // program symbols
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;

    // input item commands
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_INPUT = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    // result item kinds
    typedef enum logic [2:0] {
        K_OUTPUT    = 3'd0,
        K_INPUT     = 3'd1,
        K_FINISHED  = 3'd2,
        K_OVERFLOW  = 3'd3,
        K_UNMATCHED = 3'd4
    } t_kind;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] prog_char;
        logic [7:0] in_value;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_we;
        logic input_we;
        logic start_run;
        logic clr_en;
        logic commit;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic active;
        logic awaiting;
        logic prog_full;
        logic clr_last;
        logic has_result;
        logic out_busy;
    } t_sts;

endpackage

[sv/brainfuck_interpreter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core
// Tape-language interpreter: loads program characters, then executes one
// character per step item with a cleared tape at each run start.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// load, give input and ignored items are done in the accept state alone; step and
// stop are accepted, then executed after the program/tape/stack memory read.
// a step that starts a run first sweeps the tape memory through its single
// write port, then passes a fetch state before the execute state.
// reset is synchronous active low and clears pointers, flags and valids.
// a pending result stalls the execute cycle until the output register frees.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bfic_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfic_pkg::t_out_item o_out_item
);

    bfic_pkg::t_ctl w_ctl;
    bfic_pkg::t_sts w_sts;

    // sequencer
    bfic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_item.cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    // memories, pointers and result register
    bfic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[sv/bfic_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfic_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bfic_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfic_ctrl
// Sequencer: accepts items, runs the tape clear sweep and the execute cycle.
// ----------------------------------------------------------------------------
module bfic_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bfic_pkg::t_cmd i_in_cmd,
    output logic          o_in_ready,
    input  bfic_pkg::t_sts i_sts,
    output bfic_pkg::t_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_FETCH = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.accept = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_cmd)
                        bfic_pkg::CMD_LOAD: begin
                            o_ctl.load_we = !i_sts.active && !i_sts.prog_full;
                        end
                        bfic_pkg::CMD_STEP: begin
                            if (!i_sts.active) begin
                                o_ctl.start_run = 1'b1;
                                n_state = S_CLEAR;
                            end else if (!i_sts.awaiting) begin
                                n_state = S_EXEC;
                            end
                        end
                        bfic_pkg::CMD_INPUT: begin
                            o_ctl.input_we = i_sts.active && i_sts.awaiting;
                        end
                        bfic_pkg::CMD_STOP: begin
                            if (i_sts.active) begin
                                n_state = S_EXEC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                o_ctl.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold while a result has nowhere to go
                if (!(i_sts.has_result && i_sts.out_busy)) begin
                    o_ctl.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/bfic_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfic_dp
// Datapath: program, tape and loop stack memories, pointers, step decode and
// the result register.
// ----------------------------------------------------------------------------
module bfic_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfic_pkg::t_in_item  i_in_item,
    input  bfic_pkg::t_ctl      i_ctl,
    output bfic_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfic_pkg::t_out_item o_out_item
);

    // run state
    logic [bfic_pkg::IP_W-1:0]    r_len;
    logic [bfic_pkg::IP_W-1:0]    r_ip;
    logic [bfic_pkg::TAPE_AW-1:0] r_tp;
    logic [bfic_pkg::LVL_W-1:0]   r_level;
    logic [bfic_pkg::IP_W-1:0]    r_skip;
    logic                         r_awaiting;
    logic                         r_active;
    logic [bfic_pkg::TAPE_AW-1:0] r_clr;
    bfic_pkg::t_cmd               r_cmd;
    logic                         r_out_valid;
    bfic_pkg::t_out_item          r_out_item;

    // next values from step decode
    logic [bfic_pkg::IP_W-1:0]    n_ip;
    logic [bfic_pkg::TAPE_AW-1:0] n_tp;
    logic [bfic_pkg::LVL_W-1:0]   n_level;
    logic [bfic_pkg::IP_W-1:0]    n_skip;
    logic                         n_awaiting;
    logic                         n_active;

    logic                         w_tape_we;
    bfic_pkg::t_cell              w_tape_wd;
    logic                         w_stk_we;
    logic                         w_res;
    bfic_pkg::t_kind              w_res_kind;
    logic [7:0]                   w_res_value;

    // memory ports
    logic [7:0]                   w_prog_rd;
    bfic_pkg::t_cell              w_cell;
    logic [bfic_pkg::PROG_AW-1:0] w_top;
    logic                         w_tram_we;
    logic [bfic_pkg::TAPE_AW-1:0] w_tram_wa;
    bfic_pkg::t_cell              w_tram_wd;
    logic [bfic_pkg::IP_W-1:0]    w_ip_inc;

    bfic_ram #(.WIDTH(8), .DEPTH(bfic_pkg::PROG_DEPTH)) u_prog (
        .i_clk   (i_clk),
        .i_we    (i_ctl.load_we),
        .i_waddr (r_len[bfic_pkg::PROG_AW-1:0]),
        .i_wdata (i_in_item.prog_char),
        .i_raddr (r_ip[bfic_pkg::PROG_AW-1:0]),
        .o_rdata (w_prog_rd)
    );

    bfic_ram #(.WIDTH(bfic_pkg::CELL_BITS), .DEPTH(bfic_pkg::TAPE_CELLS)) u_tape (
        .i_clk   (i_clk),
        .i_we    (w_tram_we),
        .i_waddr (w_tram_wa),
        .i_wdata (w_tram_wd),
        .i_raddr (r_tp),
        .o_rdata (w_cell)
    );

    bfic_ram #(.WIDTH(bfic_pkg::PROG_AW), .DEPTH(bfic_pkg::STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_ctl.commit && w_stk_we),
        .i_waddr (r_level[bfic_pkg::STK_AW-1:0]),
        .i_wdata (r_ip[bfic_pkg::PROG_AW-1:0]),
        .i_raddr (bfic_pkg::STK_AW'(r_level - 1'b1)),
        .o_rdata (w_top)
    );

    // tape write port: clear sweep, given input, executed step
    always_comb begin
        w_tram_we = 1'b0;
        w_tram_wa = r_tp;
        w_tram_wd = w_tape_wd;
        priority if (i_ctl.clr_en) begin
            w_tram_we = 1'b1;
            w_tram_wa = r_clr;
            w_tram_wd = '0;
        end else if (i_ctl.input_we) begin
            w_tram_we = 1'b1;
            w_tram_wd = bfic_pkg::t_cell'(i_in_item.in_value);
        end else if (i_ctl.commit && w_tape_we) begin
            w_tram_we = 1'b1;
        end
    end

    assign w_ip_inc = bfic_pkg::IP_W'(r_ip + 1'b1);

    // step and stop decode
    always_comb begin
        n_ip        = r_ip;
        n_tp        = r_tp;
        n_level     = r_level;
        n_skip      = r_skip;
        n_awaiting  = r_awaiting;
        n_active    = r_active;
        w_tape_we   = 1'b0;
        w_tape_wd   = w_cell;
        w_stk_we    = 1'b0;
        w_res       = 1'b0;
        w_res_kind  = bfic_pkg::K_FINISHED;
        w_res_value = '0;
        if (r_cmd == bfic_pkg::CMD_STOP || r_ip >= r_len) begin
            // run ends
            n_active   = 1'b0;
            n_awaiting = 1'b0;
            w_res      = 1'b1;
        end else if (r_skip != '0) begin
            // skipping forward over a loop body
            if (w_prog_rd == bfic_pkg::CH_OPEN) begin
                n_skip = bfic_pkg::IP_W'(r_skip + 1'b1);
            end else if (w_prog_rd == bfic_pkg::CH_CLOSE) begin
                n_skip = bfic_pkg::IP_W'(r_skip - 1'b1);
            end
            n_ip = w_ip_inc;
        end else begin
            n_ip = w_ip_inc;
            unique case (w_prog_rd)
                bfic_pkg::CH_PLUS: begin
                    w_tape_we = 1'b1;
                    w_tape_wd = bfic_pkg::t_cell'(w_cell + 1'b1);
                end
                bfic_pkg::CH_MINUS: begin
                    w_tape_we = 1'b1;
                    w_tape_wd = bfic_pkg::t_cell'(w_cell - 1'b1);
                end
                bfic_pkg::CH_RIGHT: begin
                    if (r_tp == bfic_pkg::TAPE_AW'(bfic_pkg::TAPE_CELLS - 1)) begin
                        n_tp = '0;
                    end else begin
                        n_tp = bfic_pkg::TAPE_AW'(r_tp + 1'b1);
                    end
                end
                bfic_pkg::CH_LEFT: begin
                    if (r_tp == '0) begin
                        n_tp = bfic_pkg::TAPE_AW'(bfic_pkg::TAPE_CELLS - 1);
                    end else begin
                        n_tp = bfic_pkg::TAPE_AW'(r_tp - 1'b1);
                    end
                end
                bfic_pkg::CH_OPEN: begin
                    if (w_cell == '0) begin
                        n_skip = bfic_pkg::IP_W'(1);
                    end else if (r_level == bfic_pkg::LVL_W'(bfic_pkg::STACK_DEPTH)) begin
                        // stack full
                        n_ip       = r_ip;
                        n_active   = 1'b0;
                        n_awaiting = 1'b0;
                        w_res      = 1'b1;
                        w_res_kind = bfic_pkg::K_OVERFLOW;
                    end else begin
                        w_stk_we = 1'b1;
                        n_level  = bfic_pkg::LVL_W'(r_level + 1'b1);
                    end
                end
                bfic_pkg::CH_CLOSE: begin
                    if (r_level == '0) begin
                        // close with no open
                        n_ip       = r_ip;
                        n_active   = 1'b0;
                        n_awaiting = 1'b0;
                        w_res      = 1'b1;
                        w_res_kind = bfic_pkg::K_UNMATCHED;
                    end else if (w_cell != '0) begin
                        n_ip = bfic_pkg::IP_W'(bfic_pkg::IP_W'(w_top) + 1'b1);
                    end else begin
                        n_level = bfic_pkg::LVL_W'(r_level - 1'b1);
                    end
                end
                bfic_pkg::CH_OUT: begin
                    w_res       = 1'b1;
                    w_res_kind  = bfic_pkg::K_OUTPUT;
                    w_res_value = w_cell[7:0];
                end
                bfic_pkg::CH_IN: begin
                    n_awaiting = 1'b1;
                    w_res      = 1'b1;
                    w_res_kind = bfic_pkg::K_INPUT;
                end
                default: ;
            endcase
        end
    end

    // run state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ip       <= '0;
            r_tp       <= '0;
            r_level    <= '0;
            r_skip     <= '0;
            r_awaiting <= 1'b0;
            r_active   <= 1'b0;
            r_clr      <= '0;
            r_cmd      <= bfic_pkg::CMD_LOAD;
        end else begin
            if (i_ctl.accept) begin
                r_cmd <= i_in_item.cmd;
            end
            if (i_ctl.load_we) begin
                r_len <= bfic_pkg::IP_W'(r_len + 1'b1);
            end
            if (i_ctl.input_we) begin
                r_awaiting <= 1'b0;
            end
            if (i_ctl.clr_en) begin
                r_clr <= bfic_pkg::TAPE_AW'(r_clr + 1'b1);
            end
            if (i_ctl.start_run) begin
                r_ip       <= '0;
                r_tp       <= '0;
                r_level    <= '0;
                r_skip     <= '0;
                r_awaiting <= 1'b0;
                r_active   <= 1'b1;
                r_clr      <= '0;
            end
            if (i_ctl.commit) begin
                r_ip       <= n_ip;
                r_tp       <= n_tp;
                r_level    <= n_level;
                r_skip     <= n_skip;
                r_awaiting <= n_awaiting;
                r_active   <= n_active;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit && w_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && w_res) begin
            r_out_item.kind  <= w_res_kind;
            r_out_item.value <= w_res_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // status to controller
    assign o_sts.active     = r_active;
    assign o_sts.awaiting   = r_awaiting;
    assign o_sts.prog_full  = (r_len == bfic_pkg::IP_W'(bfic_pkg::PROG_DEPTH));
    assign o_sts.clr_last   = (r_clr == bfic_pkg::TAPE_AW'(bfic_pkg::TAPE_CELLS - 1));
    assign o_sts.has_result = w_res;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

endmodule

[tb/brainfuck_interpreter_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_tb
// Self-checking bench for the tape-language interpreter core. Programs are
// built from gated segments, so that every run can skip the older segments
// and reach the newest one. Each run is stepped through while inputs are
// answered and ignored items are mixed in. A tracker class predicts every
// result item and checks the output channel against it. The last run skips
// every segment and ends on a stray close bracket.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core_tb;

    // interpreter tracker: own copy of the machine state plus pending results
    class interp_tracker;
        logic [7:0]          prog_mem [bfic_pkg::PROG_DEPTH];
        int unsigned         prog_len;
        int unsigned         ip;
        int unsigned         tp;
        int unsigned         stk_lvl;
        int unsigned         skip_cnt;
        int unsigned         loop_stk [bfic_pkg::STACK_DEPTH];
        bfic_pkg::t_cell     tape_mem [int unsigned];
        bit                  awaiting;
        bit                  active;
        bit                  finished;
        bfic_pkg::t_out_item pending_results [$];
        int                  errors;

        function new();
            prog_len = 0;
            ip       = 0;
            tp       = 0;
            stk_lvl  = 0;
            skip_cnt = 0;
            awaiting = 0;
            active   = 0;
            finished = 0;
            errors   = 0;
        endfunction

        function bfic_pkg::t_cell cell_rd(int unsigned addr);
            return tape_mem.exists(addr) ? tape_mem[addr] : '0;
        endfunction

        function void close_run();
            active   = 0;
            finished = 1;
            awaiting = 0;
        endfunction

        // execute the character under the instruction pointer
        function bit exec_char(output bfic_pkg::t_out_item r);
            logic [7:0]      ch;
            bfic_pkg::t_cell c_val;
            r.kind  = bfic_pkg::K_FINISHED;
            r.value = '0;
            if (ip >= prog_len || ip >= bfic_pkg::PROG_DEPTH) begin
                close_run();
                return 1;
            end
            ch    = prog_mem[ip];
            c_val = cell_rd(tp);
            // forward skip over a loop body entered on a zero cell
            if (skip_cnt > 0) begin
                if (ch == bfic_pkg::CH_OPEN) begin
                    skip_cnt++;
                end else if (ch == bfic_pkg::CH_CLOSE) begin
                    skip_cnt--;
                end
                ip++;
                return 0;
            end
            case (ch)
                bfic_pkg::CH_PLUS: begin
                    tape_mem[tp] = c_val + 1'b1;
                end
                bfic_pkg::CH_MINUS: begin
                    tape_mem[tp] = c_val - 1'b1;
                end
                bfic_pkg::CH_RIGHT: begin
                    tp = (tp + 1 >= bfic_pkg::TAPE_CELLS) ? 0 : tp + 1;
                end
                bfic_pkg::CH_LEFT: begin
                    tp = (tp == 0) ? bfic_pkg::TAPE_CELLS - 1 : tp - 1;
                end
                bfic_pkg::CH_OPEN: begin
                    if (c_val == '0) begin
                        skip_cnt = 1;
                    end else begin
                        if (stk_lvl >= bfic_pkg::STACK_DEPTH) begin
                            r.kind = bfic_pkg::K_OVERFLOW;
                            close_run();
                            return 1;
                        end
                        loop_stk[stk_lvl] = ip;
                        stk_lvl++;
                    end
                end
                bfic_pkg::CH_CLOSE: begin
                    if (stk_lvl == 0) begin
                        r.kind = bfic_pkg::K_UNMATCHED;
                        close_run();
                        return 1;
                    end
                    if (c_val != '0) begin
                        ip = loop_stk[stk_lvl - 1] + 1;
                        return 0;
                    end
                    stk_lvl--;
                end
                bfic_pkg::CH_OUT: begin
                    ip++;
                    r.kind  = bfic_pkg::K_OUTPUT;
                    r.value = c_val;
                    return 1;
                end
                bfic_pkg::CH_IN: begin
                    awaiting = 1;
                    ip++;
                    r.kind = bfic_pkg::K_INPUT;
                    return 1;
                end
                default: begin
                end
            endcase
            ip++;
            return 0;
        endfunction

        // accepted input item: update state and queue what it causes
        function void note_item(bfic_pkg::t_in_item it);
            bit                  has;
            bfic_pkg::t_out_item r;
            has = 0;
            case (it.cmd)
                bfic_pkg::CMD_LOAD: begin
                    if (!active && prog_len < bfic_pkg::PROG_DEPTH) begin
                        prog_mem[prog_len] = it.prog_char;
                        prog_len++;
                    end
                end
                bfic_pkg::CMD_STEP: begin
                    // a step with no run active starts one on a clean tape
                    if (!active) begin
                        tape_mem.delete();
                        tp       = 0;
                        ip       = 0;
                        stk_lvl  = 0;
                        skip_cnt = 0;
                        awaiting = 0;
                        active   = 1;
                        finished = 0;
                    end
                    if (!awaiting) begin
                        has = exec_char(r);
                    end
                end
                bfic_pkg::CMD_INPUT: begin
                    if (active && awaiting) begin
                        tape_mem[tp] = it.in_value;
                        awaiting     = 0;
                    end
                end
                default: begin
                    if (active) begin
                        close_run();
                        r.kind  = bfic_pkg::K_FINISHED;
                        r.value = '0;
                        has     = 1;
                    end
                end
            endcase
            if (has) begin
                pending_results.push_back(r);
            end
        endfunction

        // accepted result item against the oldest prediction
        function void check_result(bfic_pkg::t_out_item got);
            bfic_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result item, expected none, actual kind %0d value %0d",
                         $time, got.kind, got.value);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t ns: kind mismatch, expected %0d actual %0d",
                         $time, want.kind, got.kind);
                errors++;
            end
            if (got.value !== want.value) begin
                $display("%0t ns: value mismatch, expected %0d actual %0d",
                         $time, want.value, got.value);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    bfic_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    bfic_pkg::t_out_item o_out_item;

    interp_tracker sb;
    int            items_sent     = 0;
    int            send_idle_pct  = 17;
    int            recv_stall_pct = 50;
    int            cur_seg        = 0;
    bit            close_owed     = 0;
    int            gate_owner [bfic_pkg::PROG_DEPTH];
    logic [7:0]    seg_text [$];

    brainfuck_interpreter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
    end

    // one input item through the handshake, then into the tracker
    task automatic send_item(bfic_pkg::t_cmd cmd, logic [7:0] pc, logic [7:0] iv);
        bfic_pkg::t_in_item it;
        it.cmd       = cmd;
        it.prog_char = pc;
        it.in_value  = iv;
        // idling pattern follows the progress of the run
        if (items_sent < 700) begin
            send_idle_pct  = 17;
            recv_stall_pct = 50;
        end else if (items_sent < 1400) begin
            send_idle_pct  = 50;
            recv_stall_pct = 17;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_item(it);
        items_sent++;
    endtask

    // load seg_text; its first character is the gate of this segment
    task automatic load_seg(int owner, bit open_tail);
        int k;
        if (close_owed) begin
            send_item(bfic_pkg::CMD_LOAD, bfic_pkg::CH_CLOSE, 8'($urandom));
        end
        gate_owner[sb.prog_len] = owner;
        for (k = 0; k < seg_text.size(); k++) begin
            send_item(bfic_pkg::CMD_LOAD, seg_text[k], 8'($urandom));
        end
        close_owed = open_tail;
    endtask

    // step one run through, answering inputs and mixing in ignored items
    task automatic run_program(int step_budget, int gate_val);
        int         steps;
        int         owner;
        logic [7:0] v;
        steps = 0;
        do begin
            if (sb.active && $urandom_range(0, 99) < 6) begin
                // load while running, or a spare input when none is wanted
                if (sb.awaiting || $urandom_range(0, 1) == 0) begin
                    send_item(bfic_pkg::CMD_LOAD, 8'($urandom), 8'($urandom));
                end else begin
                    send_item(bfic_pkg::CMD_INPUT, 8'($urandom), 8'($urandom));
                end
            end else if (sb.awaiting) begin
                owner = gate_owner[sb.ip - 1];
                if ($urandom_range(0, 99) < 12) begin
                    send_item(bfic_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
                end else if (cur_seg >= 0 && (owner < 0 || owner == cur_seg)
                             && $urandom_range(0, 99) < 3) begin
                    send_item(bfic_pkg::CMD_STOP, 8'($urandom), 8'($urandom));
                end else begin
                    // older gates stay shut, the current one opens
                    if (owner >= 0 && owner != cur_seg) begin
                        v = 8'd0;
                    end else if (owner >= 0) begin
                        v = (gate_val >= 0) ? 8'(gate_val) : 8'($urandom_range(1, 4));
                    end else if ($urandom_range(0, 3) == 0) begin
                        v = 8'($urandom);
                    end else begin
                        v = 8'($urandom_range(0, 3));
                    end
                    send_item(bfic_pkg::CMD_INPUT, 8'($urandom), v);
                end
            end else begin
                send_item(bfic_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
                steps++;
            end
        end while (sb.active && steps < step_budget);
        if (sb.active) begin
            send_item(bfic_pkg::CMD_STOP, 8'($urandom), 8'($urandom));
        end
    endtask

    // stimulus
    initial begin
        string      first_prog;
        int         k;
        int         seg;
        int         blen;
        int         depth;
        bit         open_tail;
        logic [7:0] c;

        sb = new();
        for (k = 0; k < bfic_pkg::PROG_DEPTH; k++) begin
            gate_owner[k] = -1;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle items are ignored; a step on an empty program finishes at once
        send_item(bfic_pkg::CMD_STOP, 8'($urandom), 8'($urandom));
        send_item(bfic_pkg::CMD_INPUT, 8'($urandom), 8'($urandom));
        send_item(bfic_pkg::CMD_STEP, 8'($urandom), 8'($urandom));

        // first segment: cell and pointer wrap, nested skip, loop back, input
        first_prog = ",[--.++.>[[]]<<,[-.].]";
        seg_text.delete();
        for (k = 0; k < first_prog.len(); k++) begin
            seg_text.push_back(first_prog[k]);
        end
        load_seg(0, 0);
        cur_seg = 0;
        send_item(bfic_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
        send_item(bfic_pkg::CMD_STEP, 8'($urandom), 8'($urandom));
        send_item(bfic_pkg::CMD_LOAD, bfic_pkg::CH_OUT, 8'($urandom));
        send_item(bfic_pkg::CMD_INPUT, 8'($urandom), 8'd1);
        run_program(200, 1);

        // random segments, each reached by skipping all older ones
        seg = 1;
        while (items_sent < 800 && seg < 15) begin
            open_tail = (seg == 4);
            seg_text.delete();
            seg_text.push_back(bfic_pkg::CH_IN);
            seg_text.push_back(bfic_pkg::CH_OPEN);
            depth = 0;
            blen  = $urandom_range(4, 14);
            for (k = 0; k < blen; k++) begin
                case ($urandom_range(0, 10))
                    0: c = bfic_pkg::CH_PLUS;
                    1: c = bfic_pkg::CH_MINUS;
                    2: c = bfic_pkg::CH_RIGHT;
                    3: c = bfic_pkg::CH_LEFT;
                    4, 8: c = bfic_pkg::CH_OUT;
                    5: c = bfic_pkg::CH_IN;
                    6: begin
                        c = bfic_pkg::CH_OPEN;
                        depth++;
                    end
                    7: begin
                        if (depth > 0) begin
                            c = bfic_pkg::CH_CLOSE;
                            depth--;
                        end else begin
                            c = bfic_pkg::CH_MINUS;
                        end
                    end
                    default: begin
                        c = 8'($urandom);
                        if (c == bfic_pkg::CH_OPEN || c == bfic_pkg::CH_CLOSE) begin
                            c = 8'h20;
                        end
                    end
                endcase
                seg_text.push_back(c);
            end
            while (depth > 0) begin
                seg_text.push_back(bfic_pkg::CH_CLOSE);
                depth--;
            end
            // an open tail leaves the gate unmatched until the next segment
            if (!open_tail) begin
                seg_text.push_back(bfic_pkg::CH_CLOSE);
            end
            load_seg(seg, open_tail);
            cur_seg = seg;
            run_program(sb.prog_len + 60, open_tail ? 0 : -1);
            // ignored items between runs
            if ($urandom_range(0, 1) == 0) begin
                send_item(bfic_pkg::CMD_STOP, 8'($urandom), 8'($urandom));
            end else begin
                send_item(bfic_pkg::CMD_INPUT, 8'($urandom), 8'($urandom));
            end
            seg++;
        end

        // nesting one level past the loop stack
        seg_text.delete();
        seg_text.push_back(bfic_pkg::CH_IN);
        seg_text.push_back(bfic_pkg::CH_OPEN);
        for (k = 0; k < bfic_pkg::STACK_DEPTH; k++) begin
            seg_text.push_back(bfic_pkg::CH_OPEN);
        end
        for (k = 0; k <= bfic_pkg::STACK_DEPTH; k++) begin
            seg_text.push_back(bfic_pkg::CH_CLOSE);
        end
        load_seg(seg, 0);
        cur_seg = seg;
        run_program(sb.prog_len + 150, 1);

        // all gates shut, so the run skips everything and meets a stray close
        send_item(bfic_pkg::CMD_LOAD, bfic_pkg::CH_CLOSE, 8'($urandom));
        cur_seg = -1;
        run_program(2 * bfic_pkg::PROG_DEPTH, 0);
        send_item(bfic_pkg::CMD_STOP, 8'($urandom), 8'($urandom));

        // drain
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bfic_pkg.sv
sv/bfic_ram.sv
sv/bfic_ctrl.sv
sv/bfic_dp.sv
sv/brainfuck_interpreter_core.sv
tb/brainfuck_interpreter_core_tb.sv
